[hw/rtl/brf_pkg.sv]
// ----------------------------------------------------------------------------
// brf_pkg
// shared types, constants and saturating fixed-point helpers of the root finder
// ----------------------------------------------------------------------------
package brf_pkg;

  localparam int DataW    = 64;
  localparam int FracW    = 32;
  localparam int EpsW     = 32;
  localparam int TolW     = 63;
  localparam int IterW    = 7;
  localparam int DivSteps = DataW + FracW;

  localparam logic signed [DataW-1:0] VMax = {1'b0, {(DataW-1){1'b1}}};
  localparam logic signed [DataW-1:0] VMin = {1'b1, {(DataW-1){1'b0}}};
  localparam logic signed [DataW-1:0] One  = DataW'(1) << FracW;

  typedef enum logic [1:0] {
    ST_EVAL  = 2'd0,
    ST_ROOT  = 2'd1,
    ST_NOBRK = 2'd2,
    ST_LIMIT = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_TOL   = 2'd0,
    CFG_EPS   = 2'd1,
    CFG_MAXIT = 2'd2,
    CFG_NONE  = 2'd3
  } cfg_idx_e;

  typedef enum logic [5:0] {
    S_IDLE, S_SWAP_SIGN, S_SWAP_ABS, S_TOL_MUL, S_TOL_DBL, S_TOL_ADD, S_XM, S_CONV,
    S_DIV_S, S_SEC_A, S_SEC_MUL, S_SEC_Q,
    S_IQ_DIV_Q, S_IQ_DIV_R, S_IQ_A, S_IQ_M1, S_IQ_B, S_IQ_M2, S_IQ_C, S_IQ_D,
    S_IQ_M3, S_IQ_E, S_IQ_M4, S_IQ_F, S_IQ_M5, S_IQ_G, S_IQ_M6,
    S_SIGN, S_M_A, S_M_B, S_M_M1, S_M_M2, S_M_C, S_M_M3, S_DEC_A, S_DEC,
    S_DIV_STEP, S_FIN, S_EMIT
  } state_e;

  function automatic logic [DataW-1:0] mag(input logic signed [DataW-1:0] x);
    mag = x[DataW-1] ? DataW'(-x) : DataW'(x);
  endfunction

  function automatic logic signed [DataW-1:0] from_mag(input logic neg,
                                                       input logic [DataW-1:0] m,
                                                       input logic over);
    logic big;
    big = m[DataW-1] && !(neg && (m[DataW-2:0] == '0));
    if (over || big) from_mag = neg ? VMin : VMax;
    else             from_mag = neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [DataW-1:0] sat_addsub(input logic signed [DataW-1:0] a,
                                                         input logic signed [DataW-1:0] b,
                                                         input logic sub);
    logic signed [DataW:0] s;
    s = sub ? ({a[DataW-1], a} - {b[DataW-1], b}) : ({a[DataW-1], a} + {b[DataW-1], b});
    if (s[DataW] != s[DataW-1]) sat_addsub = s[DataW] ? VMin : VMax;
    else                        sat_addsub = s[DataW-1:0];
  endfunction

  function automatic logic signed [DataW-1:0] sabs(input logic signed [DataW-1:0] x);
    if (!x[DataW-1])    sabs = x;
    else if (x == VMin) sabs = VMax;
    else                sabs = -x;
  endfunction

  function automatic logic same_sign(input logic signed [DataW-1:0] x,
                                     input logic signed [DataW-1:0] y);
    same_sign = (x != '0) && (y != '0) && (x[DataW-1] == y[DataW-1]);
  endfunction

  function automatic logic signed [DataW-1:0] half(input logic signed [DataW-1:0] x);
    logic signed [DataW-1:0] t;
    t = x + DataW'(x[DataW-1]);
    half = t >>> 1;
  endfunction

endpackage

[hw/rtl/brent_root_finder_step_top.sv]
// ----------------------------------------------------------------------------
// brent_root_finder_step_top
// Brent-Dekker root finder step engine, Q32.32, function evaluated outside
// ----------------------------------------------------------------------------
// A start beat (tuser 0) loads the bracket and both end values; each later
// beat (tuser 1) brings the function value at the last proposed abscissa. Every
// accepted beat of a running search, and every start, yields one result beat.
// The block accepts no beat while a step is computed. A converged step ends
// after the tolerance and midpoint states, a bisection step adds S_FIN. An
// interpolation step also waits on the shared bit-serial divider (up to four
// quotients per step) and the shared multiplier (up to ten products per step).
// A stalled result beat holds the step that follows it in S_EMIT until taken.
// A value beat with no search running is dropped without a result.
module brent_root_finder_step_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // bracket_low, bracket_high, value_low, value_high, new_value
  input  logic [5*brf_pkg::DataW-1:0] s_axis_tdata,
  // func
  input  logic [0:0]                s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // abscissa
  output logic [brf_pkg::DataW-1:0] m_axis_tdata,
  // status
  output logic [1:0]                m_axis_tuser,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [brf_pkg::TolW-1:0]  cfg_data_i
);
  import brf_pkg::*;

  typedef logic signed [DataW-1:0] val_t;

  state_e state_q, state_d;

  logic [TolW-1:0]  tol_q;
  logic [EpsW-1:0]  eps_q;
  logic [IterW-1:0] maxit_q;

  val_t bp_q, bp_d, pp_q, pp_d, cp_q, cp_d;
  val_t bv_q, bv_d, pv_q, pv_d, cv_q, cv_d;
  val_t sn_q, sn_d, sb_q, sb_d;
  val_t tol1_q, tol1_d, xm_q, xm_d, tmp_q, tmp_d;
  val_t s_q, s_d, p_q, p_d, q_q, q_d, qq_q, qq_d, r_q, r_d;
  val_t t1_q, t1_d, t2_q, t2_d, m1_q, m1_d, m2_q, m2_d;
  val_t res_x_q, res_x_d;
  status_e res_st_q, res_st_d;
  logic [IterW-1:0] iter_q, iter_d;
  logic active_q, active_d, started_q, started_d;

  logic    out_valid_q;
  val_t    out_x_q;
  status_e out_st_q;

  val_t alu_a, alu_b, alu_y;
  logic alu_sub;
  val_t mul_a, mul_b, mul_y, div_a, div_b, div_y;
  logic mul_go, div_go, mul_done, div_done;

  val_t in_bl, in_bh, in_vl, in_vh, in_nv;
  logic fire, is_start, start_bad, at_limit;
  logic c_same, c_swap, c_root, c_interp, c_accept;
  val_t mmin;
  logic emit_free;

  assign in_bl = s_axis_tdata[1*DataW-1:0*DataW];
  assign in_bh = s_axis_tdata[2*DataW-1:1*DataW];
  assign in_vl = s_axis_tdata[3*DataW-1:2*DataW];
  assign in_vh = s_axis_tdata[4*DataW-1:3*DataW];
  assign in_nv = s_axis_tdata[5*DataW-1:4*DataW];

  assign s_axis_tready = (state_q == S_IDLE);
  assign fire      = s_axis_tvalid && s_axis_tready;
  assign is_start  = !s_axis_tuser[0];
  assign start_bad = same_sign(in_vl, in_vh);
  assign at_limit  = iter_q >= maxit_q;
  assign emit_free = !out_valid_q || m_axis_tready;

  assign c_same   = same_sign(bv_q, cv_q);
  assign c_swap   = sabs(cv_q) < sabs(bv_q);
  assign c_root   = (sabs(xm_q) <= tol1_q) || (bv_q == '0);
  assign c_interp = (sabs(sb_q) >= tol1_q) && (sabs(pv_q) > sabs(bv_q));
  assign mmin     = (m1_q < m2_q) ? m1_q : m2_q;
  assign c_accept = tmp_q < mmin;

  assign alu_y = sat_addsub(alu_a, alu_b, alu_sub);

  brf_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_go),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .y_o    (mul_y)
  );

  brf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_go),
    .a_i    (div_a),
    .b_i    (div_b),
    .done_o (div_done),
    .y_o    (div_y)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (fire) begin
          if (is_start) state_d = start_bad ? S_EMIT : S_SWAP_SIGN;
          else if (active_q) state_d = at_limit ? S_EMIT : S_SWAP_SIGN;
        end
      end
      S_SWAP_SIGN: state_d = S_SWAP_ABS;
      S_SWAP_ABS:  state_d = S_TOL_MUL;
      S_TOL_MUL:   if (mul_done) state_d = S_TOL_DBL;
      S_TOL_DBL:   state_d = S_TOL_ADD;
      S_TOL_ADD:   state_d = S_XM;
      S_XM:        state_d = S_CONV;
      S_CONV: begin
        if (c_root)        state_d = S_EMIT;
        else if (c_interp) state_d = S_DIV_S;
        else               state_d = S_FIN;
      end
      S_DIV_S:     if (div_done) state_d = (pp_q == cp_q) ? S_SEC_A : S_IQ_DIV_Q;
      S_SEC_A:     state_d = S_SEC_MUL;
      S_SEC_MUL:   if (mul_done) state_d = S_SEC_Q;
      S_SEC_Q:     state_d = S_SIGN;
      S_IQ_DIV_Q:  if (div_done) state_d = S_IQ_DIV_R;
      S_IQ_DIV_R:  if (div_done) state_d = S_IQ_A;
      S_IQ_A:      state_d = S_IQ_M1;
      S_IQ_M1:     if (mul_done) state_d = S_IQ_B;
      S_IQ_B:      state_d = S_IQ_M2;
      S_IQ_M2:     if (mul_done) state_d = S_IQ_C;
      S_IQ_C:      state_d = S_IQ_D;
      S_IQ_D:      state_d = S_IQ_M3;
      S_IQ_M3:     if (mul_done) state_d = S_IQ_E;
      S_IQ_E:      state_d = S_IQ_M4;
      S_IQ_M4:     if (mul_done) state_d = S_IQ_F;
      S_IQ_F:      state_d = S_IQ_M5;
      S_IQ_M5:     if (mul_done) state_d = S_IQ_G;
      S_IQ_G:      state_d = S_IQ_M6;
      S_IQ_M6:     if (mul_done) state_d = S_SIGN;
      S_SIGN:      state_d = S_M_A;
      S_M_A:       state_d = S_M_B;
      S_M_B:       state_d = S_M_M1;
      S_M_M1:      if (mul_done) state_d = S_M_M2;
      S_M_M2:      if (mul_done) state_d = S_M_C;
      S_M_C:       state_d = S_M_M3;
      S_M_M3:      if (mul_done) state_d = S_DEC_A;
      S_DEC_A:     state_d = S_DEC;
      S_DEC:       state_d = c_accept ? S_DIV_STEP : S_FIN;
      S_DIV_STEP:  if (div_done) state_d = S_FIN;
      S_FIN:       state_d = S_EMIT;
      S_EMIT:      if (emit_free) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  // datapath and unit control
  always_comb begin
    bp_d = bp_q;  pp_d = pp_q;  cp_d = cp_q;
    bv_d = bv_q;  pv_d = pv_q;  cv_d = cv_q;
    sn_d = sn_q;  sb_d = sb_q;
    tol1_d = tol1_q;  xm_d = xm_q;  tmp_d = tmp_q;
    s_d = s_q;  p_d = p_q;  q_d = q_q;  qq_d = qq_q;  r_d = r_q;
    t1_d = t1_q;  t2_d = t2_q;  m1_d = m1_q;  m2_d = m2_q;
    res_x_d = res_x_q;  res_st_d = res_st_q;
    iter_d = iter_q;  active_d = active_q;
    alu_a = '0;  alu_b = '0;  alu_sub = 1'b0;
    mul_a = '0;  mul_b = '0;  div_a = '0;  div_b = '0;
    mul_go = 1'b0;  div_go = 1'b0;
    started_d = started_q;

    unique case (state_q)
      S_IDLE: begin
        if (fire && is_start) begin
          pp_d = in_bl;  bp_d = in_bh;  pv_d = in_vl;  bv_d = in_vh;
          if (start_bad) begin
            active_d = 1'b0;  res_x_d = '0;  res_st_d = ST_NOBRK;
          end else begin
            cp_d = in_bh;  cv_d = in_vh;  iter_d = IterW'(1);  active_d = 1'b1;
          end
        end else if (fire && active_q) begin
          bv_d = in_nv;
          if (at_limit) begin
            active_d = 1'b0;  res_x_d = bp_q;  res_st_d = ST_LIMIT;
          end else begin
            iter_d = iter_q + IterW'(1);
          end
        end
      end
      S_SWAP_SIGN: begin
        alu_a = bp_q;  alu_b = pp_q;  alu_sub = 1'b1;
        if (c_same) begin
          cp_d = pp_q;  cv_d = pv_q;  sn_d = alu_y;  sb_d = alu_y;
        end
      end
      S_SWAP_ABS: begin
        if (c_swap) begin
          pp_d = bp_q;  bp_d = cp_q;  cp_d = bp_q;
          pv_d = bv_q;  bv_d = cv_q;  cv_d = bv_q;
        end
      end
      S_TOL_MUL: begin
        mul_a = sabs(bp_q);  mul_b = val_t'({{(DataW-EpsW){1'b0}}, eps_q});
        if (mul_done) tmp_d = mul_y;
      end
      S_TOL_DBL: begin
        alu_a = tmp_q;  alu_b = tmp_q;  tol1_d = alu_y;
      end
      S_TOL_ADD: begin
        alu_a = tol1_q;  alu_b = val_t'({2'b00, tol_q[TolW-1:1]});  tol1_d = alu_y;
      end
      S_XM: begin
        alu_a = cp_q;  alu_b = bp_q;  alu_sub = 1'b1;  xm_d = half(alu_y);
      end
      S_CONV: begin
        if (c_root) begin
          active_d = 1'b0;  res_x_d = bp_q;  res_st_d = ST_ROOT;
        end else if (!c_interp) begin
          sn_d = xm_q;  sb_d = xm_q;
        end
      end
      S_DIV_S: begin
        div_a = bv_q;  div_b = pv_q;
        if (div_done) s_d = div_y;
      end
      S_SEC_A: begin
        alu_a = xm_q;  alu_b = xm_q;  tmp_d = alu_y;
      end
      S_SEC_MUL: begin
        mul_a = tmp_q;  mul_b = s_q;
        if (mul_done) p_d = mul_y;
      end
      S_SEC_Q: begin
        alu_a = One;  alu_b = s_q;  alu_sub = 1'b1;  q_d = alu_y;
      end
      S_IQ_DIV_Q: begin
        div_a = pv_q;  div_b = cv_q;
        if (div_done) qq_d = div_y;
      end
      S_IQ_DIV_R: begin
        div_a = bv_q;  div_b = cv_q;
        if (div_done) r_d = div_y;
      end
      S_IQ_A: begin
        alu_a = xm_q;  alu_b = xm_q;  tmp_d = alu_y;
      end
      S_IQ_M1: begin
        mul_a = tmp_q;  mul_b = qq_q;
        if (mul_done) t1_d = mul_y;
      end
      S_IQ_B: begin
        alu_a = qq_q;  alu_b = r_q;  alu_sub = 1'b1;  tmp_d = alu_y;
      end
      S_IQ_M2: begin
        mul_a = t1_q;  mul_b = tmp_q;
        if (mul_done) t1_d = mul_y;
      end
      S_IQ_C: begin
        alu_a = bp_q;  alu_b = pp_q;  alu_sub = 1'b1;  tmp_d = alu_y;
      end
      S_IQ_D: begin
        alu_a = r_q;  alu_b = One;  alu_sub = 1'b1;  r_d = alu_y;
      end
      S_IQ_M3: begin
        mul_a = tmp_q;  mul_b = r_q;
        if (mul_done) t2_d = mul_y;
      end
      S_IQ_E: begin
        alu_a = t1_q;  alu_b = t2_q;  alu_sub = 1'b1;  tmp_d = alu_y;
      end
      S_IQ_M4: begin
        mul_a = s_q;  mul_b = tmp_q;
        if (mul_done) p_d = mul_y;
      end
      S_IQ_F: begin
        alu_a = qq_q;  alu_b = One;  alu_sub = 1'b1;  tmp_d = alu_y;
      end
      S_IQ_M5: begin
        mul_a = tmp_q;  mul_b = r_q;
        if (mul_done) q_d = mul_y;
      end
      S_IQ_G: begin
        alu_a = s_q;  alu_b = One;  alu_sub = 1'b1;  tmp_d = alu_y;
      end
      S_IQ_M6: begin
        mul_a = q_q;  mul_b = tmp_q;
        if (mul_done) q_d = mul_y;
      end
      S_SIGN: begin
        alu_a = '0;  alu_b = q_q;  alu_sub = 1'b1;
        if (p_q > 0) q_d = alu_y;
        p_d = sabs(p_q);
      end
      S_M_A: begin
        alu_a = xm_q;  alu_b = xm_q;  tmp_d = alu_y;
      end
      S_M_B: begin
        alu_a = tmp_q;  alu_b = xm_q;  tmp_d = alu_y;
      end
      S_M_M1: begin
        mul_a = tmp_q;  mul_b = q_q;
        if (mul_done) m1_d = mul_y;
      end
      S_M_M2: begin
        mul_a = tol1_q;  mul_b = q_q;
        if (mul_done) t2_d = mul_y;
      end
      S_M_C: begin
        alu_a = m1_q;  alu_b = sabs(t2_q);  alu_sub = 1'b1;  m1_d = alu_y;
      end
      S_M_M3: begin
        mul_a = sb_q;  mul_b = q_q;
        if (mul_done) m2_d = sabs(mul_y);
      end
      S_DEC_A: begin
        alu_a = p_q;  alu_b = p_q;  tmp_d = alu_y;
      end
      S_DEC: begin
        if (c_accept) begin
          sb_d = sn_q;
        end else begin
          sn_d = xm_q;  sb_d = xm_q;
        end
      end
      S_DIV_STEP: begin
        div_a = p_q;  div_b = q_q;
        if (div_done) sn_d = div_y;
      end
      S_FIN: begin
        alu_a = bp_q;
        if (sabs(sn_q) > tol1_q) begin
          alu_b = sn_q;
        end else begin
          alu_b = tol1_q;  alu_sub = xm_q[DataW-1];
        end
        pp_d = bp_q;  pv_d = bv_q;  bp_d = alu_y;
        res_x_d = alu_y;  res_st_d = ST_EVAL;
      end
      S_EMIT: ;
      default: ;
    endcase

    // one launch per unit state, cleared when the unit answers
    unique case (state_q)
      S_TOL_MUL, S_SEC_MUL, S_IQ_M1, S_IQ_M2, S_IQ_M3, S_IQ_M4, S_IQ_M5, S_IQ_M6,
      S_M_M1, S_M_M2, S_M_M3: begin
        mul_go    = !started_q;
        started_d = !mul_done;
      end
      S_DIV_S, S_IQ_DIV_Q, S_IQ_DIV_R, S_DIV_STEP: begin
        div_go    = !started_q;
        started_d = !div_done;
      end
      default: started_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= 1'b0;
      iter_q      <= '0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
      tol_q       <= TolW'(4295);
      eps_q       <= EpsW'(429);
      maxit_q     <= IterW'(100);
    end else begin
      state_q   <= state_d;
      active_q  <= active_d;
      iter_q    <= iter_d;
      started_q <= started_d;
      if (state_q == S_EMIT && emit_free) out_valid_q <= 1'b1;
      else if (m_axis_tready)             out_valid_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_TOL:   tol_q   <= cfg_data_i;
          CFG_EPS:   eps_q   <= cfg_data_i[EpsW-1:0];
          CFG_MAXIT: maxit_q <= cfg_data_i[IterW-1:0];
          CFG_NONE:  ;
          default:   ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    bp_q <= bp_d;  pp_q <= pp_d;  cp_q <= cp_d;
    bv_q <= bv_d;  pv_q <= pv_d;  cv_q <= cv_d;
    sn_q <= sn_d;  sb_q <= sb_d;
    tol1_q <= tol1_d;  xm_q <= xm_d;  tmp_q <= tmp_d;
    s_q <= s_d;  p_q <= p_d;  q_q <= q_d;  qq_q <= qq_d;  r_q <= r_d;
    t1_q <= t1_d;  t2_q <= t2_d;  m1_q <= m1_d;  m2_q <= m2_d;
    res_x_q <= res_x_d;  res_st_q <= res_st_d;
    if (state_q == S_EMIT && emit_free) begin
      out_x_q  <= res_x_q;
      out_st_q <= res_st_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_x_q;
  assign m_axis_tuser  = out_st_q;

endmodule

[hw/rtl/brf_mul.sv]
// ----------------------------------------------------------------------------
// brf_mul
// saturating fixed-point multiplier, one 32x32 partial product per cycle
// ----------------------------------------------------------------------------
module brf_mul (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [63:0]       a_i,
  input  logic signed [63:0]       b_i,
  output logic                     done_o,
  output logic signed [63:0]       y_o
);
  import brf_pkg::*;

  localparam int HalfW = DataW / 2;

  logic             busy_q, done_q;
  logic [1:0]       cnt_q;
  logic [DataW-1:0] ua_q, ub_q;
  logic             neg_q;
  logic [2*DataW-1:0] acc_q, addend;
  logic [HalfW-1:0] ah, bh;
  logic [DataW-1:0] pp;

  assign ah = cnt_q[0] ? ua_q[DataW-1:HalfW] : ua_q[HalfW-1:0];
  assign bh = cnt_q[1] ? ub_q[DataW-1:HalfW] : ub_q[HalfW-1:0];
  assign pp = ah * bh;

  always_comb begin
    case ({1'b0, cnt_q[0]} + {1'b0, cnt_q[1]})
      2'd0:    addend = {{DataW{1'b0}}, pp};
      2'd1:    addend = {{HalfW{1'b0}}, pp, {HalfW{1'b0}}};
      default: addend = {pp, {DataW{1'b0}}};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ua_q  <= mag(a_i);
      ub_q  <= mag(b_i);
      neg_q <= a_i[DataW-1] ^ b_i[DataW-1];
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + addend;
    end
  end

  assign done_o = done_q;
  assign y_o    = from_mag(neg_q, acc_q[DataW+FracW-1:FracW], |acc_q[2*DataW-1:DataW+FracW]);

endmodule

[hw/rtl/brf_div.sv]
// ----------------------------------------------------------------------------
// brf_div
// saturating fixed-point divider, restoring, one quotient bit per cycle
// ----------------------------------------------------------------------------
module brf_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] a_i,
  input  logic signed [63:0] b_i,
  output logic               done_o,
  output logic signed [63:0] y_o
);
  import brf_pkg::*;

  logic                  busy_q, done_q, zero_q;
  logic [IterW-1:0]      cnt_q;
  logic [DivSteps-1:0]   num_q;
  logic [DataW-1:0]      rem_q, ub_q;
  logic                  neg_q;
  logic signed [DataW-1:0] zres_q;
  logic [DataW:0]        rem2, diff;
  logic                  ge;

  assign rem2 = {rem_q, num_q[DivSteps-1]};
  assign diff = rem2 - {1'b0, ub_q};
  assign ge   = rem2 >= {1'b0, ub_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= '0;
        if (b_i == '0) done_q <= 1'b1;
        else           busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q + IterW'(1);
        if (cnt_q == IterW'(DivSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      zero_q <= (b_i == '0);
      zres_q <= a_i[DataW-1] ? VMin : ((a_i == '0) ? '0 : VMax);
      ub_q   <= mag(b_i);
      num_q  <= {mag(a_i), {FracW{1'b0}}};
      rem_q  <= '0;
      neg_q  <= a_i[DataW-1] ^ b_i[DataW-1];
    end else if (busy_q) begin
      rem_q <= ge ? diff[DataW-1:0] : rem2[DataW-1:0];
      num_q <= {num_q[DivSteps-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign y_o    = zero_q ? zres_q
                         : from_mag(neg_q, num_q[DataW-1:0], |num_q[DivSteps-1:DataW]);

endmodule

[hw/rtl/brf_checker.sv]
// ----------------------------------------------------------------------------
// brf_checker
// port-level checks of the root finder, bound to the top level
// ----------------------------------------------------------------------------
module brf_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic [0:0]                  s_axis_tuser,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [brf_pkg::DataW-1:0]   m_axis_tdata,
  input logic [1:0]                  m_axis_tuser
);
  import brf_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // a start beat always keeps the block busy for the next cycle
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser[0] |=> !s_axis_tready)
    else $error("ready right after a start beat");

  // not-bracketed result carries a zero abscissa
  a_nobrk_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_NOBRK) |-> (m_axis_tdata == '0))
    else $error("not-bracketed beat with nonzero abscissa");

  // a new result only appears after the block left the ready state
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result beat without a finished step");

endmodule

bind brent_root_finder_step_top brf_checker u_brf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
